// ===== hw/rtl/tilt_complementary_filter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// tilt complementary filter assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef TILT_COMPLEMENTARY_FILTER_UNIT_MACROS_SVH
`define TILT_COMPLEMENTARY_FILTER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define TCF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define TCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg
// shared types, constants and helpers of the tilt complementary filter
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

	typedef struct packed {
		logic               command;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_roll;
		logic signed [15:0] rate_pitch;
	} item_t;

	typedef struct packed {
		logic               start;
		logic signed [17:0] y;
		logic signed [17:0] x;
	} cordic_req_t;

	typedef struct packed {
		logic               done;
		logic signed [16:0] ang;
		logic signed [17:0] mag;
	} cordic_rsp_t;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic        [15:0] INV_GAIN_Q15 = 16'd19898;
	localparam logic        [15:0] BLEND_RESET  = 16'd655;
	localparam logic        [23:0] RECIP_1000   = 24'd8589935;
	localparam logic        [24:0] ROUND_1000   = 25'd500;
	localparam logic signed [16:0] ANGLE_RIGHT  = 17'sd9000;
	localparam logic signed [16:0] ANGLE_HALF   = 17'sd18000;
	localparam logic signed [33:0] DIFF_CLAMP   = 34'sd3000000;
	localparam logic signed [27:0] GYRO_SAT     = 28'sd51200000;
	localparam logic signed [24:0] OUT_MAX      = 25'sd65535;
	localparam logic signed [24:0] OUT_MIN      = -25'sd65536;

	function automatic logic signed [23:0] atan_q8(input logic [3:0] idx);
		logic signed [23:0] v;
		case (idx)
			4'd0:    v = 24'sd1152000;
			4'd1:    v = 24'sd680065;
			4'd2:    v = 24'sd359328;
			4'd3:    v = 24'sd182400;
			4'd4:    v = 24'sd91554;
			4'd5:    v = 24'sd45822;
			4'd6:    v = 24'sd22916;
			4'd7:    v = 24'sd11459;
			4'd8:    v = 24'sd5730;
			4'd9:    v = 24'sd2865;
			4'd10:   v = 24'sd1432;
			4'd11:   v = 24'sd716;
			4'd12:   v = 24'sd358;
			4'd13:   v = 24'sd179;
			default: v = 24'sd0;
		endcase
		return v;
	endfunction

	// q8 to centi-degrees, half away from zero
	function automatic logic signed [24:0] q8_round(input logic signed [31:0] q);
		logic [31:0] m;
		logic [32:0] r;
		m = q[31] ? 32'(-q) : 32'(q);
		r = {1'b0, m} + 33'd128;
		return q[31] ? -$signed(r[32:8]) : $signed(r[32:8]);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcf_front.sv =====
// ----------------------------------------------------------------------------
// tcf_front
// input side: takes transactions and holds them in a short queue
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire tcf_pkg::item_t in_item,
	output tcf_pkg::item_t     head,
	output logic               head_valid,
	input  wire logic          head_pop
);

	tcf_pkg::item_t                     mem_q [tcf_pkg::FIFO_DEPTH];
	logic [tcf_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
	logic [tcf_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
	logic [tcf_pkg::FIFO_PTR_W:0]       cnt_q;
	logic                               do_push;
	logic                               do_pop;

	assign full       = (cnt_q == (tcf_pkg::FIFO_PTR_W+1)'(tcf_pkg::FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tcf_cordic.sv =====
// ----------------------------------------------------------------------------
// tcf_cordic
// iterative cordic vectoring unit: atan2 in centi-degrees and magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_cordic #(
	parameter int CORDIC_STEPS   = 14,
	parameter int INPUT_PRESHIFT = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tcf_pkg::cordic_req_t req,
	output tcf_pkg::cordic_rsp_t     rsp
);

	localparam int CW    = INPUT_PRESHIFT + 21;
	localparam int DW    = CW - INPUT_PRESHIFT;
	localparam int PW    = DW + 17;
	localparam int CNT_W = $clog2(CORDIC_STEPS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

	typedef enum logic [4:0] {
		C_IDLE = 5'b00001,
		C_ITER = 5'b00010,
		C_RND  = 5'b00100,
		C_MUL  = 5'b01000,
		C_MAG  = 5'b10000
	} cstate_t;

	cstate_t                  state_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [CW-1:0]     xv_q;
	logic signed [CW-1:0]     yv_q;
	logic signed [23:0]       acc_q;
	logic signed [16:0]       add_q;
	logic signed [16:0]       ang_q;
	logic signed [17:0]       mag_q;
	logic signed [DW-1:0]     d_q;
	logic signed [PW-1:0]     prod_q;

	logic                     x_neg;
	logic                     x_zero;
	logic signed [17:0]       xa;
	logic signed [17:0]       ya;
	logic signed [CW-1:0]     xs;
	logic signed [CW-1:0]     ys;
	logic signed [23:0]       step_ang;
	logic signed [CW-1:0]     rnd_sum;
	logic signed [CW-1:0]     rnd_sh;
	logic signed [24:0]       acc_cd;
	logic signed [PW-1:0]     mag_sum;
	logic signed [PW-1:0]     mag_sh;

	assign x_neg    = req.x[17];
	assign x_zero   = (req.x == '0);
	assign xa       = x_neg ? -req.x : req.x;
	assign ya       = x_neg ? -req.y : req.y;
	assign xs       = xv_q >>> cnt_q;
	assign ys       = yv_q >>> cnt_q;
	assign step_ang = tcf_pkg::atan_q8(4'(cnt_q));
	assign rnd_sum  = xv_q + (CW'(1) <<< (INPUT_PRESHIFT - 1));
	assign rnd_sh   = rnd_sum >>> INPUT_PRESHIFT;
	assign acc_cd   = tcf_pkg::q8_round(32'(acc_q));
	assign mag_sum  = prod_q + PW'(16384);
	assign mag_sh   = mag_sum >>> 15;

	assign rsp.done = done_q;
	assign rsp.ang  = ang_q;
	assign rsp.mag  = mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (req.start) begin
						if (x_zero) begin
							done_q <= 1'b1;
						end else begin
							cnt_q   <= '0;
							state_q <= C_ITER;
						end
					end
				end
				C_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						state_q <= C_RND;
					end
				end
				C_RND: begin
					state_q <= C_MUL;
				end
				C_MUL: begin
					state_q <= C_MAG;
				end
				C_MAG: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (req.start) begin
					if (x_zero) begin
						// vertical vector: fixed angle, magnitude is |y|
						if (req.y > 0) begin
							ang_q <= tcf_pkg::ANGLE_RIGHT;
						end else if (req.y < 0) begin
							ang_q <= -tcf_pkg::ANGLE_RIGHT;
						end else begin
							ang_q <= '0;
						end
						mag_q <= req.y[17] ? -req.y : req.y;
					end else begin
						xv_q  <= CW'(xa) <<< INPUT_PRESHIFT;
						yv_q  <= CW'(ya) <<< INPUT_PRESHIFT;
						acc_q <= '0;
						if (x_neg) begin
							add_q <= req.y[17] ? -tcf_pkg::ANGLE_HALF : tcf_pkg::ANGLE_HALF;
						end else begin
							add_q <= '0;
						end
					end
				end
			end
			C_ITER: begin
				if (!yv_q[CW-1]) begin
					xv_q  <= xv_q + ys;
					yv_q  <= yv_q - xs;
					acc_q <= acc_q + step_ang;
				end else begin
					xv_q  <= xv_q - ys;
					yv_q  <= yv_q + xs;
					acc_q <= acc_q - step_ang;
				end
			end
			C_RND: begin
				ang_q <= acc_cd[16:0] + add_q;
				d_q   <= rnd_sh[DW-1:0];
			end
			C_MUL: begin
				prod_q <= d_q * $signed({1'b0, tcf_pkg::INV_GAIN_Q15});
			end
			C_MAG: begin
				mag_q <= mag_sh[17:0];
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tcf_back.sv =====
// ----------------------------------------------------------------------------
// tcf_back
// execution side: tilt sequencing, gyro integration, blend and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tcf_pkg::item_t       head,
	input  wire logic                 head_valid,
	output logic                      head_pop,
	output tcf_pkg::cordic_req_t      creq,
	input  wire tcf_pkg::cordic_rsp_t crsp,
	input  wire logic                 cfg_wen,
	input  wire logic [15:0]          cfg_wdata,
	output logic                      empty,
	input  wire logic                 pop,
	output logic signed [16:0]        roll_angle,
	output logic signed [16:0]        pitch_angle,
	output logic signed [18:0]        roll_gyro_angle,
	output logic signed [18:0]        pitch_gyro_angle
);

	typedef enum logic [12:0] {
		B_IDLE  = 13'b0000000000001,
		B_RGO   = 13'b0000000000010,
		B_RWAIT = 13'b0000000000100,
		B_PGO   = 13'b0000000001000,
		B_PWAIT = 13'b0000000010000,
		B_DR    = 13'b0000000100000,
		B_DP    = 13'b0000001000000,
		B_PRED  = 13'b0000010000000,
		B_CR    = 13'b0000100000000,
		B_CP    = 13'b0001000000000,
		B_UPD   = 13'b0010000000000,
		B_SNAP  = 13'b0100000000000,
		B_OUT   = 13'b1000000000000
	} bstate_t;

	bstate_t             state_q;
	tcf_pkg::item_t      item_q;
	logic [15:0]         gain_q;
	logic                out_valid_q;
	logic signed [16:0]  roll_cd_q;
	logic signed [16:0]  pitch_cd_q;
	logic signed [17:0]  mag_q;
	logic [48:0]         mprod_q;
	logic signed [15:0]  dr_q;
	logic signed [15:0]  dp_q;
	logic signed [31:0]  pr_q;
	logic signed [31:0]  pp_q;
	logic signed [39:0]  bprod_q;
	logic signed [31:0]  roll_est_q;
	logic signed [31:0]  pitch_est_q;
	logic signed [26:0]  roll_trk_q;
	logic signed [26:0]  pitch_trk_q;
	logic signed [16:0]  roll_out_q;
	logic signed [16:0]  pitch_out_q;
	logic signed [18:0]  roll_gyro_out_q;
	logic signed [18:0]  pitch_gyro_out_q;

	logic signed [17:0]  ax_ext;
	logic                out_write;
	logic signed [33:0]  diff;
	logic signed [22:0]  diff_c;
	logic signed [26:0]  corr;
	logic signed [15:0]  dp_now;
	logic signed [24:0]  roll_cd_out;
	logic signed [24:0]  pitch_cd_out;
	logic signed [24:0]  roll_gyro_cd;
	logic signed [24:0]  pitch_gyro_cd;

	function automatic logic [48:0] delta_prod(input logic signed [15:0] rate);
		logic signed [16:0] r;
		logic [16:0]        a;
		logic [24:0]        n;
		r = 17'(rate);
		a = r[16] ? 17'(-r) : 17'(r);
		n = {a, 8'b0} + tcf_pkg::ROUND_1000;
		return 49'(n) * 49'(tcf_pkg::RECIP_1000);
	endfunction

	function automatic logic signed [15:0] delta_fix(input logic [48:0] p, input logic neg);
		logic signed [15:0] q;
		q = $signed(p[48:33]);
		return neg ? -q : q;
	endfunction

	function automatic logic signed [26:0] round_q15(input logic signed [39:0] p);
		logic [39:0] m;
		logic [40:0] r;
		m = p[39] ? 40'(-p) : 40'(p);
		r = {1'b0, m} + 41'd16384;
		return p[39] ? -$signed({1'b0, r[40:15]}) : $signed({1'b0, r[40:15]});
	endfunction

	function automatic logic signed [26:0] gyro_add(input logic signed [26:0] t,
	                                                input logic signed [15:0] d);
		logic signed [27:0] s;
		s = 28'(t) + 28'(d);
		if (s > tcf_pkg::GYRO_SAT) begin
			s = tcf_pkg::GYRO_SAT;
		end else if (s < -tcf_pkg::GYRO_SAT) begin
			s = -tcf_pkg::GYRO_SAT;
		end
		return s[26:0];
	endfunction

	function automatic logic signed [16:0] out_clamp(input logic signed [24:0] v);
		logic signed [24:0] c;
		c = v;
		if (v > tcf_pkg::OUT_MAX) begin
			c = tcf_pkg::OUT_MAX;
		end else if (v < tcf_pkg::OUT_MIN) begin
			c = tcf_pkg::OUT_MIN;
		end
		return c[16:0];
	endfunction

	assign ax_ext     = 18'(item_q.accel_x);
	assign head_pop   = (state_q == B_IDLE) && head_valid;
	assign creq.start = (state_q == B_RGO) || (state_q == B_PGO);
	assign creq.y     = (state_q == B_RGO) ? 18'(item_q.accel_y) : -ax_ext;
	assign creq.x     = (state_q == B_RGO) ? 18'(item_q.accel_z) : mag_q;

	assign out_write  = (state_q == B_OUT) && (!out_valid_q || pop);

	assign empty            = !out_valid_q;
	assign roll_angle       = roll_out_q;
	assign pitch_angle      = pitch_out_q;
	assign roll_gyro_angle  = roll_gyro_out_q;
	assign pitch_gyro_angle = pitch_gyro_out_q;

	// blend operand: roll in the roll step, pitch otherwise
	always_comb begin
		if (state_q == B_CR) begin
			diff = (34'(roll_cd_q) <<< 8) - 34'(pr_q);
		end else begin
			diff = (34'(pitch_cd_q) <<< 8) - 34'(pp_q);
		end
		if (diff > tcf_pkg::DIFF_CLAMP) begin
			diff_c = tcf_pkg::DIFF_CLAMP[22:0];
		end else if (diff < -tcf_pkg::DIFF_CLAMP) begin
			diff_c = 23'(-tcf_pkg::DIFF_CLAMP);
		end else begin
			diff_c = diff[22:0];
		end
	end

	assign corr          = round_q15(bprod_q);
	assign dp_now        = delta_fix(mprod_q, item_q.rate_pitch[15]);
	assign roll_cd_out   = tcf_pkg::q8_round(roll_est_q);
	assign pitch_cd_out  = tcf_pkg::q8_round(pitch_est_q);
	assign roll_gyro_cd  = tcf_pkg::q8_round(32'(roll_trk_q));
	assign pitch_gyro_cd = tcf_pkg::q8_round(32'(pitch_trk_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			gain_q      <= tcf_pkg::BLEND_RESET;
			out_valid_q <= 1'b0;
			roll_est_q  <= '0;
			pitch_est_q <= '0;
			roll_trk_q  <= '0;
			pitch_trk_q <= '0;
		end else begin
			if (cfg_wen) begin
				gain_q <= cfg_wdata;
			end
			if (out_write) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (head_valid) begin
						state_q <= B_RGO;
					end
				end
				B_RGO: begin
					state_q <= B_RWAIT;
				end
				B_RWAIT: begin
					if (crsp.done) begin
						state_q <= B_PGO;
					end
				end
				B_PGO: begin
					state_q <= B_PWAIT;
				end
				B_PWAIT: begin
					if (crsp.done) begin
						state_q <= item_q.command ? B_SNAP : B_DR;
					end
				end
				B_DR: begin
					state_q <= B_DP;
				end
				B_DP: begin
					state_q <= B_PRED;
				end
				B_PRED: begin
					state_q <= B_CR;
				end
				B_CR: begin
					state_q <= B_CP;
				end
				B_CP: begin
					roll_est_q <= pr_q + 32'(corr);
					state_q    <= B_UPD;
				end
				B_UPD: begin
					pitch_est_q <= pp_q + 32'(corr);
					roll_trk_q  <= gyro_add(roll_trk_q, dr_q);
					pitch_trk_q <= gyro_add(pitch_trk_q, dp_q);
					state_q     <= B_OUT;
				end
				B_SNAP: begin
					roll_est_q  <= 32'(roll_cd_q) <<< 8;
					pitch_est_q <= 32'(pitch_cd_q) <<< 8;
					roll_trk_q  <= 27'(roll_cd_q) <<< 8;
					pitch_trk_q <= 27'(pitch_cd_q) <<< 8;
					state_q     <= B_OUT;
				end
				B_OUT: begin
					if (out_write) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			item_q <= head;
		end
		if ((state_q == B_RWAIT) && crsp.done) begin
			roll_cd_q <= crsp.ang;
			mag_q     <= crsp.mag;
		end
		if ((state_q == B_PWAIT) && crsp.done) begin
			pitch_cd_q <= crsp.ang;
		end
		case (state_q)
			B_DR: begin
				mprod_q <= delta_prod(item_q.rate_roll);
			end
			B_DP: begin
				dr_q    <= delta_fix(mprod_q, item_q.rate_roll[15]);
				mprod_q <= delta_prod(item_q.rate_pitch);
			end
			B_PRED: begin
				dp_q <= dp_now;
				pr_q <= roll_est_q + 32'(dr_q);
				pp_q <= pitch_est_q + 32'(dp_now);
			end
			B_CR: begin
				bprod_q <= 40'(diff_c) * 40'($signed({1'b0, gain_q}));
			end
			B_CP: begin
				bprod_q <= 40'(diff_c) * 40'($signed({1'b0, gain_q}));
			end
			default: begin
			end
		endcase
		if (out_write) begin
			roll_out_q       <= out_clamp(roll_cd_out);
			pitch_out_q      <= out_clamp(pitch_cd_out);
			roll_gyro_out_q  <= roll_gyro_cd[18:0];
			pitch_gyro_out_q <= pitch_gyro_cd[18:0];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tilt_complementary_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tilt_complementary_filter_unit
// accelerometer tilt via cordic, blended with integrated gyro rate
// ----------------------------------------------------------------------------
// Each input transaction is one sensor tick and yields exactly one result. A
// two-entry input queue takes transactions while the execution side works; one
// shared iterative cordic unit runs twice per tick (roll, then pitch from the
// roll magnitude), one step per cycle followed by rounding, gain-multiply and
// magnitude steps. A reset command skips the gyro integration and blend steps, and a zero
// accel_z skips the roll iterations. The finished result sits in an output
// register, so the next tick starts while the result waits to be popped.
// blend_gain may be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_complementary_filter_unit #(
	parameter int CORDIC_STEPS   = 14,
	parameter int INPUT_PRESHIFT = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               command,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] rate_roll,
	input  wire logic signed [15:0] rate_pitch,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [16:0]      roll_angle,
	output logic signed [16:0]      pitch_angle,
	output logic signed [18:0]      roll_gyro_angle,
	output logic signed [18:0]      pitch_gyro_angle,
	input  wire logic               cfg_wen,
	input  wire logic [15:0]        cfg_wdata
);

	tcf_pkg::item_t       in_item;
	tcf_pkg::item_t       head;
	logic                 head_valid;
	logic                 head_pop;
	tcf_pkg::cordic_req_t creq;
	tcf_pkg::cordic_rsp_t crsp;

	assign in_item.command    = command;
	assign in_item.accel_x    = accel_x;
	assign in_item.accel_y    = accel_y;
	assign in_item.accel_z    = accel_z;
	assign in_item.rate_roll  = rate_roll;
	assign in_item.rate_pitch = rate_pitch;

	tcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	tcf_cordic #(
		.CORDIC_STEPS   (CORDIC_STEPS),
		.INPUT_PRESHIFT (INPUT_PRESHIFT)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	tcf_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.head_valid       (head_valid),
		.head_pop         (head_pop),
		.creq             (creq),
		.crsp             (crsp),
		.cfg_wen          (cfg_wen),
		.cfg_wdata        (cfg_wdata),
		.empty            (empty),
		.pop              (pop),
		.roll_angle       (roll_angle),
		.pitch_angle      (pitch_angle),
		.roll_gyro_angle  (roll_gyro_angle),
		.pitch_gyro_angle (pitch_gyro_angle)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/tcf_checker.sv =====
// ----------------------------------------------------------------------------
// tcf_checker
// port-level checks of the tilt complementary filter
// ----------------------------------------------------------------------------
`default_nettype none

`include "tilt_complementary_filter_unit_macros.svh"

module tcf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               push,
	input wire logic               full,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic signed [16:0] roll_angle,
	input wire logic signed [16:0] pitch_angle,
	input wire logic signed [18:0] roll_gyro_angle,
	input wire logic signed [18:0] pitch_gyro_angle
);

	logic [2:0] pend_q;
	logic       in_xact;
	logic       out_xact;

	assign in_xact  = push && !full;
	assign out_xact = pop && !empty;

	// transactions taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xact && !out_xact) begin
			pend_q <= pend_q + 1'b1;
		end else if (!in_xact && out_xact) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`TCF_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(roll_angle) && $stable(pitch_angle) && $stable(roll_gyro_angle) && $stable(pitch_gyro_angle), "waiting result changed")
	`TCF_ASSERT_NOW(a_no_spurious, !empty, pend_q != 3'd0, "result without pending transaction")
	`TCF_ASSERT_NOW(a_full_backlog, full, pend_q >= 3'd2, "full with short backlog")
	`TCF_ASSERT_NOW(a_gyro_range, !empty, roll_gyro_angle <= 19'sd200000 && roll_gyro_angle >= -19'sd200000 && pitch_gyro_angle <= 19'sd200000 && pitch_gyro_angle >= -19'sd200000, "gyro angle out of range")

endmodule

bind tilt_complementary_filter_unit tcf_checker u_tcf_checker (.*);

`default_nettype wire

// ===== test/tilt_complementary_filter_unit_test.sv =====
// ----------------------------------------------------------------------------
// tilt_complementary_filter_unit_test
// drives sensor ticks through the filter and checks every result against an
// in-bench fixed-point predictor of the cordic tilt and the blended tracks
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_complementary_filter_unit_test;

	typedef struct {
		logic signed [16:0] roll;
		logic signed [16:0] pitch;
		logic signed [18:0] roll_gyro;
		logic signed [18:0] pitch_gyro;
	} angles_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic command = 1'b0;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic signed [15:0] rate_roll = '0;
	logic signed [15:0] rate_pitch = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [16:0] roll_angle;
	logic signed [16:0] pitch_angle;
	logic signed [18:0] roll_gyro_angle;
	logic signed [18:0] pitch_gyro_angle;
	logic cfg_wen = 1'b0;
	logic [15:0] cfg_wdata = '0;

	angles_t expected_angles[$];
	longint gain;
	longint roll_est, pitch_est, roll_gyro_trk, pitch_gyro_trk;
	int mismatches = 0;
	longint cycles = 0;
	int hold_off = 0;
	bit pop_stall_enable = 1'b1;

	localparam longint CYCLE_LIMIT = 400000;

	tilt_complementary_filter_unit i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.rate_roll(rate_roll), .rate_pitch(rate_pitch), .empty(empty), .pop(pop),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.roll_gyro_angle(roll_gyro_angle), .pitch_gyro_angle(pitch_gyro_angle),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic longint shr(longint v, int n);
		return (v >= 0) ? (v >>> n) : (-1 - ((-1 - v) >>> n));
	endfunction

	function automatic longint to_cd(longint q);
		return (q >= 0) ? ((q + 128) >>> 8) : -((-q + 128) >>> 8);
	endfunction

	function automatic longint limit(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint wrap_word(longint v);
		logic signed [31:0] w;
		w = v[31:0];
		return longint'(w);
	endfunction

	function automatic longint arctan_step(int i);
		longint steps[14] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
			11459, 5730, 2865, 1432, 716, 358, 179};
		return steps[i];
	endfunction

	task automatic vector_angle(input longint y, input longint x, output longint ang,
		output longint mag);
		longint add, xv, yv, acc, xs, ys, d;
		add = 0; xv = x; yv = y; acc = 0;
		if (x == 0) begin
			ang = (y > 0) ? 9000 : ((y < 0) ? -9000 : 0);
			mag = (y < 0) ? -y : y;
		end else begin
			if (x < 0) begin
				xv = -x;
				yv = -y;
				add = (y >= 0) ? 18000 : -18000;
			end
			xv = xv * 4096;
			yv = yv * 4096;
			for (int i = 0; i < 14; i++) begin
				xs = shr(xv, i);
				ys = shr(yv, i);
				if (yv >= 0) begin
					xv += ys; yv -= xs; acc += arctan_step(i);
				end else begin
					xv -= ys; yv += xs; acc -= arctan_step(i);
				end
			end
			ang = to_cd(acc) + add;
			d = shr(xv + 2048, 12);
			mag = shr(d * 19898 + 16384, 15);
		end
	endtask

	function automatic longint rate_delta(longint rate);
		longint n;
		n = rate * 256;
		return (n >= 0) ? (n + 500) / 1000 : -((-n + 500) / 1000);
	endfunction

	function automatic longint pull(longint diff);
		longint p;
		p = limit(diff, -3000000, 3000000) * gain;
		return (p >= 0) ? ((p + 16384) >>> 15) : -((-p + 16384) >>> 15);
	endfunction

	task automatic predict_tick(input logic cmd, input longint ax, input longint ay,
		input longint az, input longint gr, input longint gp);
		longint tilt_roll, tilt_pitch, mag, unused, dr, dp, pr, pp;
		angles_t a;
		vector_angle(ay, az, tilt_roll, mag);
		vector_angle(-ax, mag, tilt_pitch, unused);
		if (cmd) begin
			roll_est = tilt_roll * 256;
			pitch_est = tilt_pitch * 256;
			roll_gyro_trk = roll_est;
			pitch_gyro_trk = pitch_est;
		end else begin
			dr = rate_delta(gr);
			dp = rate_delta(gp);
			pr = wrap_word(roll_est + dr);
			pp = wrap_word(pitch_est + dp);
			roll_est = wrap_word(pr + pull(tilt_roll * 256 - pr));
			pitch_est = wrap_word(pp + pull(tilt_pitch * 256 - pp));
			roll_gyro_trk = limit(roll_gyro_trk + dr, -51200000, 51200000);
			pitch_gyro_trk = limit(pitch_gyro_trk + dp, -51200000, 51200000);
		end
		a.roll = 17'(limit(to_cd(roll_est), -65536, 65535));
		a.pitch = 17'(limit(to_cd(pitch_est), -65536, 65535));
		a.roll_gyro = 19'(to_cd(roll_gyro_trk));
		a.pitch_gyro = 19'(to_cd(pitch_gyro_trk));
		expected_angles.push_back(a);
	endtask

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result side: random stalls plus an optional long hold-off
	initial begin
		int stall;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				pop <= 1'b0;
			end else if (pop_stall_enable && $urandom_range(0, 3) == 0) begin
				stall = gap_length();
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
				pop <= 1'b1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		angles_t e;
		if (arst_n && pop && !empty) begin
			if (expected_angles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: %0d %0d %0d %0d", roll_angle,
						pitch_angle, roll_gyro_angle, pitch_gyro_angle);
			end else begin
				e = expected_angles.pop_front();
				if (roll_angle !== e.roll || pitch_angle !== e.pitch ||
					roll_gyro_angle !== e.roll_gyro || pitch_gyro_angle !== e.pitch_gyro) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
							e.roll, e.pitch, e.roll_gyro, e.pitch_gyro, roll_angle,
							pitch_angle, roll_gyro_angle, pitch_gyro_angle);
				end
			end
		end
	end

	task automatic send_tick(input logic cmd, input logic signed [15:0] ax,
		input logic signed [15:0] ay, input logic signed [15:0] az,
		input logic signed [15:0] gr, input logic signed [15:0] gp, input bit gaps);
		int g;
		command <= cmd;
		accel_x <= ax;
		accel_y <= ay;
		accel_z <= az;
		rate_roll <= gr;
		rate_pitch <= gp;
		push <= 1'b1;
		do @(posedge clk); while (full);
		predict_tick(cmd, ax, ay, az, gr, gp);
		g = gaps ? gap_length() : 0;
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_angles.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_gain(input logic [15:0] value);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		gain = value;
	endtask

	function automatic logic signed [15:0] rand_accel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'($urandom);
		if (r == 1) return 16'sd0;
		return 16'($signed($urandom_range(0, 4000)) - 2000);
	endfunction

	function automatic logic signed [15:0] rand_rate();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'($urandom);
		if (r == 1) return ($urandom_range(0, 1)) ? 16'sd25000 : -16'sd25000;
		return 16'($signed($urandom_range(0, 10000)) - 5000);
	endfunction

	task automatic test_directed();
		send_tick(1'b1, 16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 1'b0);
		send_tick(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_tick(1'b0, 16'sd0, 16'sd1000, 16'sd0, 16'sd25000, -16'sd25000, 1'b0);
		send_tick(1'b0, 16'sd0, -16'sd1000, 16'sd0, -16'sd25000, 16'sd25000, 1'b0);
		send_tick(1'b0, 16'sd500, 16'sd700, -16'sd800, 16'sd1, -16'sd1, 1'b0);
		send_tick(1'b0, -16'sd500, -16'sd700, -16'sd800, 16'sd2, -16'sd2, 1'b0);
		send_tick(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
		send_tick(1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
		send_tick(1'b1, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 1'b0);
		send_tick(1'b0, 16'sh7fff, 16'sd0, 16'sh8000, -16'sd1, 16'sd1, 1'b0);
		send_tick(1'b1, 16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_tick(1'b0, -16'sd1000, 16'sd1, -16'sd1, 16'sd499, -16'sd499, 1'b1);
		drain();
	endtask

	task automatic test_gyro_saturation();
		for (int i = 0; i < 90; i++)
			send_tick(1'b0, 16'sd0, 16'sd0, 16'sd1000, 16'sh7fff, 16'sh8000, 1'b0);
		send_tick(1'b0, 16'sd0, 16'sd0, 16'sd1000, -16'sd25000, 16'sd25000, 1'b0);
		drain();
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_tick(($urandom_range(0, 19) == 0), rand_accel(), rand_accel(),
				rand_accel(), rand_rate(), rand_rate(), (i % 50) < 35);
		drain();
	endtask

	task automatic test_backpressure();
		hold_off = 400;
		for (int i = 0; i < 20; i++)
			send_tick(1'b0, rand_accel(), rand_accel(), rand_accel(), rand_rate(),
				rand_rate(), 1'b0);
		drain();
	endtask

	initial begin
		gain = 655;
		roll_est = 0; pitch_est = 0; roll_gyro_trk = 0; pitch_gyro_trk = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_gyro_saturation();
		test_random(150);
		write_gain(16'd0);
		test_random(60);
		write_gain(16'd32768);
		test_random(60);
		write_gain(16'hffff);
		test_random(60);
		write_gain(16'($urandom_range(1, 8000)));
		test_backpressure();
		pop_stall_enable = 1'b0;
		test_random(80);
		pop_stall_enable = 1'b1;
		write_gain(16'd655);
		test_random(80);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tcf_pkg.sv
hw/rtl/tcf_front.sv
hw/rtl/tcf_cordic.sv
hw/rtl/tcf_back.sv
hw/rtl/tilt_complementary_filter_unit.sv
hw/rtl/tcf_checker.sv
test/tilt_complementary_filter_unit_test.sv
